>>> hdl/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types, codes and constants of the clock set key controller.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int unsigned ValW    = 6;
  localparam int unsigned ScreenW = 3;
  localparam int unsigned TgtW    = 3;
  localparam int unsigned DirtyW  = 4;
  localparam int unsigned WrW     = 5;   // hour, minute, second, month, day

  localparam logic [ValW:0]    HourLimit      = 7'd24;
  localparam logic [ValW:0]    MinuteLimit    = 7'd60;
  localparam logic [ValW:0]    MonthLimit     = 7'd13;
  localparam logic [ValW:0]    DayLimit       = 7'd32;
  localparam logic [ValW-1:0]  SecondOnMinute = 6'd30;
  localparam logic [ScreenW:0] ScreenCount    = 4'd5;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_CHANGE = 2'd1,
    ACT_ENTER  = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  typedef enum logic [TgtW-1:0] {
    TGT_HOUR   = 3'd0,
    TGT_MINUTE = 3'd1,
    TGT_SECOND = 3'd2,
    TGT_MONTH  = 3'd3,
    TGT_DAY    = 3'd4
  } target_e;

  // Edit screens
  localparam logic [ScreenW-1:0] ScrHour   = 3'd1;
  localparam logic [ScreenW-1:0] ScrMinute = 3'd2;
  localparam logic [ScreenW-1:0] ScrMonth  = 3'd3;
  localparam logic [ScreenW-1:0] ScrDay    = 3'd4;

  // Dirty flag bits
  localparam int unsigned DirtyHour   = 0;
  localparam int unsigned DirtyMinute = 1;
  localparam int unsigned DirtyMonth  = 2;
  localparam int unsigned DirtyDay    = 3;

  // One decoded item, handed from the step logic to the emitter.
  typedef struct packed {
    logic [WrW-1:0]     wr_mask;  // bit order follows target_e
    logic [ValW-1:0]    hour;
    logic [ValW-1:0]    minute;
    logic [ValW-1:0]    month;
    logic [ValW-1:0]    day;
    logic               setting_mode;
    logic [ScreenW-1:0] screen;
    logic               show_date;
    logic               show_temp;
    logic               refresh;
  } job_t;

  // Raise a field by one, falling back to floor once the limit is reached.
  function automatic logic [ValW-1:0] raise_field(input logic [ValW-1:0] v,
                                                  input logic [ValW:0]   limit,
                                                  input logic [ValW-1:0] floor_v);
    logic [ValW:0] n;
    n = {1'b0, v} + 7'd1;
    if (n >= limit) begin
      return floor_v;
    end
    return n[ValW-1:0];
  endfunction

endpackage

>>> hdl/ckc_if.sv
// ----------------------------------------------------------------------------
// ckc_in_if / ckc_out_if
// Valid/ready channels of the clock set key controller.
// ----------------------------------------------------------------------------
interface ckc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_month;
  logic [5:0] load_day;

  modport source (output valid, action, load_hour, load_minute, load_month, load_day,
                  input ready);
  modport sink   (input valid, action, load_hour, load_minute, load_month, load_day,
                  output ready);
endinterface

interface ckc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] target_field;
  logic [5:0] write_value;
  logic       setting_mode;
  logic [2:0] screen;
  logic       show_date;
  logic       show_temp;
  logic       refresh;
  logic       last;

  modport source (output valid, kind, target_field, write_value, setting_mode, screen,
                  show_date, show_temp, refresh, last,
                  input ready);
  modport sink   (input valid, kind, target_field, write_value, setting_mode, screen,
                  show_date, show_temp, refresh, last,
                  output ready);
endinterface

>>> hdl/clock_set_key_controller_core.sv
// ----------------------------------------------------------------------------
// clock_set_key_controller_core
// Three-key clock setting controller: screens, views, edit fields, chip writes.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          beat contents
//   -------  ---  -----------------  ---------------------------------------
//   in_i     in   valid/ready        action, load_hour/minute/month/day
//   out_o    out  valid/ready        kind, target_field, write_value, status,
//                                    refresh, last
//
// Flow: an input beat is taken every cycle while the result side keeps up
//   and no write burst is pending. Each item gives one result beat, or one
//   to five chip write beats for an enter key with dirty fields; the result
//   register sends one beat a cycle while out_o.ready is high. Input reaches
//   the first result through the input register, then the result register.
// Reset: rst_ni clears the input/result valids and all controller state.
// Stalls: a held out_o.ready freezes the result register; the input register
//   then fills and in_i.ready drops until the last beat of the item leaves.
// ----------------------------------------------------------------------------
module clock_set_key_controller_core
  import ckc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ckc_in_if.sink    in_i,
  ckc_out_if.source out_o
);

  // Decoded item travelling from the state update to the result register
  logic job_valid;
  logic job_ready;
  job_t job;

  ckc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  ckc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_o       (out_o)
  );

endmodule

>>> hdl/ckc_step.sv
// ----------------------------------------------------------------------------
// ckc_step
// Input register, controller state and the per-key state update.
// ----------------------------------------------------------------------------
module ckc_step
  import ckc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ckc_in_if.sink        in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output job_t          job_o
);

  // Input register
  logic              in_v_q;
  action_e           act_q;
  logic [ValW-1:0]   ld_hour_q, ld_minute_q, ld_month_q, ld_day_q;

  // Controller state
  logic               mode_q, mode_d;
  logic [ScreenW-1:0] screen_q, screen_d;
  logic               date_q, date_d;
  logic               temp_q, temp_d;
  logic               any_q, any_d;
  logic [DirtyW-1:0]  dirty_q, dirty_d;
  logic [ValW-1:0]    hour_q, hour_d, minute_q, minute_d;
  logic [ValW-1:0]    month_q, month_d, day_q, day_d;

  logic               refresh;
  logic [WrW-1:0]     wr_mask;
  logic [ScreenW:0]   screen_inc;
  logic               advance;

  assign advance    = in_v_q && job_ready_i;
  assign in_i.ready = !in_v_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q       <= action_e'(in_i.action);
      ld_hour_q   <= in_i.load_hour;
      ld_minute_q <= in_i.load_minute;
      ld_month_q  <= in_i.load_month;
      ld_day_q    <= in_i.load_day;
    end
  end

  assign screen_inc = {1'b0, screen_q} + 4'd1;

  always_comb begin
    mode_d   = mode_q;
    screen_d = screen_q;
    date_d   = date_q;
    temp_d   = temp_q;
    any_d    = any_q;
    dirty_d  = dirty_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    month_d  = month_q;
    day_d    = day_q;
    refresh  = 1'b0;
    wr_mask  = '0;
    unique case (act_q)
      ACT_SET: begin
        if (screen_inc >= ScreenCount) begin
          screen_d = '0;
          mode_d   = 1'b0;
          refresh  = 1'b1;
          any_d    = 1'b0;
          dirty_d  = '0;
        end else begin
          screen_d = screen_inc[ScreenW-1:0];
          mode_d   = 1'b1;
        end
      end
      ACT_CHANGE: begin
        if (!mode_q) begin
          date_d = !date_q;
        end else begin
          unique case (screen_q)
            ScrHour: begin
              hour_d = raise_field(hour_q, HourLimit, 6'd0);
              any_d  = 1'b1;
              dirty_d[DirtyHour] = 1'b1;
            end
            ScrMinute: begin
              minute_d = raise_field(minute_q, MinuteLimit, 6'd0);
              any_d    = 1'b1;
              dirty_d[DirtyMinute] = 1'b1;
            end
            ScrMonth: begin
              month_d = raise_field(month_q, MonthLimit, 6'd1);
              any_d   = 1'b1;
              dirty_d[DirtyMonth] = 1'b1;
            end
            ScrDay: begin
              day_d = raise_field(day_q, DayLimit, 6'd1);
              any_d = 1'b1;
              dirty_d[DirtyDay] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ACT_ENTER: begin
        if (!mode_q) begin
          temp_d = !temp_q;
        end else if (!any_q) begin
          mode_d   = 1'b0;
          screen_d = '0;
          refresh  = 1'b1;
        end else if (dirty_q != '0) begin
          any_d   = 1'b0;
          dirty_d = '0;
          wr_mask[TGT_HOUR]   = dirty_q[DirtyHour];
          wr_mask[TGT_MINUTE] = dirty_q[DirtyMinute];
          wr_mask[TGT_SECOND] = dirty_q[DirtyMinute];
          wr_mask[TGT_MONTH]  = dirty_q[DirtyMonth];
          wr_mask[TGT_DAY]    = dirty_q[DirtyDay];
        end
      end
      ACT_LOAD: begin
        hour_d   = ld_hour_q;
        minute_d = ld_minute_q;
        month_d  = ld_month_q;
        day_d    = ld_day_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      screen_q <= '0;
      date_q   <= 1'b0;
      temp_q   <= 1'b0;
      any_q    <= 1'b0;
      dirty_q  <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      month_q  <= '0;
      day_q    <= '0;
    end else if (advance) begin
      mode_q   <= mode_d;
      screen_q <= screen_d;
      date_q   <= date_d;
      temp_q   <= temp_d;
      any_q    <= any_d;
      dirty_q  <= dirty_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      month_q  <= month_d;
      day_q    <= day_d;
    end
  end

  // Writes carry the edit values as they stood; enter never alters them.
  assign job_valid_o         = in_v_q;
  assign job_o.wr_mask       = wr_mask;
  assign job_o.hour          = hour_q;
  assign job_o.minute        = minute_q;
  assign job_o.month         = month_q;
  assign job_o.day           = day_q;
  assign job_o.setting_mode  = mode_d;
  assign job_o.screen        = screen_d;
  assign job_o.show_date     = date_d;
  assign job_o.show_temp     = temp_d;
  assign job_o.refresh       = refresh;

endmodule

>>> hdl/ckc_emit.sv
// ----------------------------------------------------------------------------
// ckc_emit
// Result register; walks the pending chip writes of one item, one per beat.
// ----------------------------------------------------------------------------
module ckc_emit
  import ckc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  ckc_out_if.source out_o
);

  logic           job_v_q;
  job_t           job_q;
  logic [WrW-1:0] mask_q, mask_d;
  logic [WrW-1:0] pick;
  logic           is_last;
  logic           out_fire;

  assign pick     = mask_q & (~mask_q + 5'd1);   // lowest pending write
  assign mask_d   = mask_q & ~pick;
  assign is_last  = (mask_d == '0);
  assign out_fire = out_o.valid && out_o.ready;

  assign job_ready_o = !job_v_q || (out_fire && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      mask_q  <= '0;
    end else if (job_ready_o) begin
      job_v_q <= job_valid_i;
      mask_q  <= job_valid_i ? job_i.wr_mask : '0;
    end else if (out_fire) begin
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      job_q <= job_i;
    end
  end

  always_comb begin
    out_o.target_field = TGT_HOUR;
    out_o.write_value  = '0;
    case (1'b1)
      pick[TGT_HOUR]: begin
        out_o.target_field = TGT_HOUR;
        out_o.write_value  = job_q.hour;
      end
      pick[TGT_MINUTE]: begin
        out_o.target_field = TGT_MINUTE;
        out_o.write_value  = job_q.minute;
      end
      pick[TGT_SECOND]: begin
        out_o.target_field = TGT_SECOND;
        out_o.write_value  = SecondOnMinute;
      end
      pick[TGT_MONTH]: begin
        out_o.target_field = TGT_MONTH;
        out_o.write_value  = job_q.month;
      end
      pick[TGT_DAY]: begin
        out_o.target_field = TGT_DAY;
        out_o.write_value  = job_q.day;
      end
      default: ;
    endcase
  end

  assign out_o.valid        = job_v_q;
  assign out_o.kind         = (mask_q != '0);
  assign out_o.setting_mode = job_q.setting_mode;
  assign out_o.screen       = job_q.screen;
  assign out_o.show_date    = job_q.show_date;
  assign out_o.show_temp    = job_q.show_temp;
  assign out_o.refresh      = job_q.refresh;
  assign out_o.last         = is_last;

endmodule

>>> tb/ckc_checker.sv
// ----------------------------------------------------------------------------
// ckc_checker
// Watches both channels of the key controller. Each accepted key beat is run
// through a local copy of the controller to get the beats it should produce.
// Each result beat is then compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ckc_checker
  import ckc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ckc_in_if    in_mon,
  ckc_out_if   out_mon,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  localparam logic KindStatus = 1'b0;
  localparam logic KindWrite  = 1'b1;
  localparam int   PrintLimit = 40;

  typedef struct packed {
    logic               kind;
    logic [TgtW-1:0]    tgt;
    logic [ValW-1:0]    value;
    logic               setting_mode;
    logic [ScreenW-1:0] screen;
    logic               show_date;
    logic               show_temp;
    logic               refresh;
    logic               last;
  } key_beat_t;

  key_beat_t expected_beats[$];
  key_beat_t head_beat;
  int        mismatches = 0;
  int        pending    = 0;
  int        result_no  = 0;

  // Local copy of the controller state
  logic               edit_on;
  logic [ScreenW-1:0] scr;
  logic               date_on;
  logic               temp_on;
  logic               changed;
  logic [DirtyW-1:0]  dirty;
  logic [ValW-1:0]    hr, mn, mo, dy;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = pending;

  // Wraps on the raised value, so loaded values past the limit wrap too.
  function automatic logic [ValW-1:0] step_field(input logic [ValW-1:0] v,
                                                 input logic [ValW:0]   limit,
                                                 input logic [ValW-1:0] wrap_to);
    if ({1'b0, v} >= limit - 7'd1) begin
      return wrap_to;
    end
    return v + 6'd1;
  endfunction

  task automatic report(input string msg);
    if (mismatches < PrintLimit) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s got %0h want %0h", result_no, name, got, want));
    end
  endtask

  task automatic add_beat(input logic kind, input logic [TgtW-1:0] tgt,
                          input logic [ValW-1:0] value, input logic refresh);
    key_beat_t b;
    b.kind         = kind;
    b.tgt          = tgt;
    b.value        = value;
    b.setting_mode = edit_on;
    b.screen       = scr;
    b.show_date    = date_on;
    b.show_temp    = temp_on;
    b.refresh      = refresh;
    b.last         = 1'b0;
    expected_beats.push_back(b);
  endtask

  task automatic predict_key(input action_e act, input logic [ValW-1:0] h,
                             input logic [ValW-1:0] mi, input logic [ValW-1:0] mth,
                             input logic [ValW-1:0] d);
    logic [DirtyW-1:0] flags;
    logic              back_to_normal;
    int                first;
    first          = expected_beats.size();
    back_to_normal = 1'b0;
    case (act)
      ACT_SET: begin
        if ({1'b0, scr} + 4'd1 >= ScreenCount) begin
          scr            = '0;
          edit_on        = 1'b0;
          changed        = 1'b0;
          dirty          = '0;
          back_to_normal = 1'b1;
        end else begin
          scr     = scr + 3'd1;
          edit_on = 1'b1;
        end
      end
      ACT_CHANGE: begin
        if (!edit_on) begin
          date_on = ~date_on;
        end else begin
          case (scr)
            ScrHour: begin
              hr = step_field(hr, HourLimit, 6'd0);
              changed = 1'b1;
              dirty[DirtyHour] = 1'b1;
            end
            ScrMinute: begin
              mn = step_field(mn, MinuteLimit, 6'd0);
              changed = 1'b1;
              dirty[DirtyMinute] = 1'b1;
            end
            ScrMonth: begin
              mo = step_field(mo, MonthLimit, 6'd1);
              changed = 1'b1;
              dirty[DirtyMonth] = 1'b1;
            end
            ScrDay: begin
              dy = step_field(dy, DayLimit, 6'd1);
              changed = 1'b1;
              dirty[DirtyDay] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ACT_ENTER: begin
        if (!edit_on) begin
          temp_on = ~temp_on;
        end else if (!changed) begin
          edit_on        = 1'b0;
          scr            = '0;
          back_to_normal = 1'b1;
        end else if (dirty != '0) begin
          flags   = dirty;
          changed = 1'b0;
          dirty   = '0;
          if (flags[DirtyHour]) add_beat(KindWrite, TGT_HOUR, hr, 1'b0);
          if (flags[DirtyMinute]) begin
            add_beat(KindWrite, TGT_MINUTE, mn, 1'b0);
            add_beat(KindWrite, TGT_SECOND, SecondOnMinute, 1'b0);
          end
          if (flags[DirtyMonth]) add_beat(KindWrite, TGT_MONTH, mo, 1'b0);
          if (flags[DirtyDay]) add_beat(KindWrite, TGT_DAY, dy, 1'b0);
        end
      end
      default: begin
        hr = h;
        mn = mi;
        mo = mth;
        dy = d;
      end
    endcase
    if (expected_beats.size() == first) begin
      add_beat(KindStatus, '0, '0, back_to_normal);
    end
    expected_beats[expected_beats.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_on = 1'b0;
      scr     = '0;
      date_on = 1'b0;
      temp_on = 1'b0;
      changed = 1'b0;
      dirty   = '0;
      hr      = '0;
      mn      = '0;
      mo      = '0;
      dy      = '0;
      expected_beats.delete();
      pending = 0;
    end else begin
      // results first: a key beat taken now cannot have produced one yet
      if (out_mon.valid && out_mon.ready) begin
        if (expected_beats.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
          head_beat = expected_beats.pop_front();
          check_field("kind", 8'(out_mon.kind), 8'(head_beat.kind));
          check_field("target_field", 8'(out_mon.target_field), 8'(head_beat.tgt));
          check_field("write_value", 8'(out_mon.write_value), 8'(head_beat.value));
          check_field("setting_mode", 8'(out_mon.setting_mode), 8'(head_beat.setting_mode));
          check_field("screen", 8'(out_mon.screen), 8'(head_beat.screen));
          check_field("show_date", 8'(out_mon.show_date), 8'(head_beat.show_date));
          check_field("show_temp", 8'(out_mon.show_temp), 8'(head_beat.show_temp));
          check_field("refresh", 8'(out_mon.refresh), 8'(head_beat.refresh));
          check_field("last", 8'(out_mon.last), 8'(head_beat.last));
        end
        result_no++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_key(action_e'(in_mon.action), in_mon.load_hour, in_mon.load_minute,
                    in_mon.load_month, in_mon.load_day);
      end
      pending = expected_beats.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the clock set key controller core.
// Feeds key and load beats: first a directed walk through every screen, field
// wrap, chip write burst and view toggle, then random key sequences. Both
// channels idle at random in several phases. The checker beside the core
// predicts and compares every result beat. The verdict is given here.
// ----------------------------------------------------------------------------
module tb_top;
  import ckc_pkg::*;

  // No accepted beat on either side for this long means the core is stuck.
  // An 80% gap or stall lasting this long is practically impossible.
  localparam int QuietLimit = 4000;
  // The first result comes through the input register, then the result register.
  // Wait TailCycles more before the verdict, so a stray extra beat is still caught.
  localparam int TailCycles = 10;
  localparam int DirectedCnt = 24;
  localparam int PhaseItems  = 89;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  ckc_in_if  in_if ();
  ckc_out_if out_if ();

  clock_set_key_controller_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  int mismatches;
  int pending;

  ckc_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Percent chance per cycle that the sender idles / the receiver stalls
  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent_cnt    = 0;
  int quiet_cycles = 0;

  // Receiver: a fresh ready decision at every falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on accepted beats.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // One key beat. Starts at the next falling edge, may idle first, then holds
  // valid until the core takes the beat. Valid stays high afterwards, so the
  // next call either keeps it up with new content or drops it for a gap.
  task automatic send_key(input action_e act, input logic [ValW-1:0] h,
                          input logic [ValW-1:0] mi, input logic [ValW-1:0] mth,
                          input logic [ValW-1:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.load_hour   <= h;
    in_if.load_minute <= mi;
    in_if.load_month  <= mth;
    in_if.load_day    <= d;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // A key press; the load fields carry noise the core must ignore.
  task automatic press(input action_e act);
    send_key(act, 6'($urandom_range(63)), 6'($urandom_range(63)),
             6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  // Loaded values: often right at or just below the wrap point, else anything.
  function automatic logic [ValW-1:0] pick_value(input logic [ValW:0] limit);
    case ($urandom_range(3))
      0:       return 6'(limit - 7'd1);
      1:       return 6'(limit - 7'd2);
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  task automatic load_time();
    send_key(ACT_LOAD, pick_value(HourLimit), pick_value(MinuteLimit),
             pick_value(MonthLimit), pick_value(DayLimit));
  endtask

  // Mostly well formed edits: optional load, walk some screens with a few
  // raises on each, then usually enter. The rest is single random actions.
  task automatic random_chunk();
    int screens;
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(1) == 1) load_time();
      screens = $urandom_range(1, 4);
      repeat (screens) begin
        press(ACT_SET);
        repeat ($urandom_range(3)) press(ACT_CHANGE);
      end
      if ($urandom_range(3) != 0) press(ACT_ENTER);
    end else if ($urandom_range(3) == 0) begin
      load_time();
    end else begin
      press(action_e'($urandom_range(2)));
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.action      = ACT_SET;
    in_if.load_hour   = '0;
    in_if.load_minute = '0;
    in_if.load_month  = '0;
    in_if.load_day    = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk, no idling.
    press(ACT_ENTER);                           // temperature view on
    press(ACT_CHANGE);                          // date view on
    send_key(ACT_LOAD, 6'd63, 6'd63, 6'd63, 6'd63);
    press(ACT_SET);                             // screen 1, setting mode
    press(ACT_CHANGE);                          // hour 63 wraps to 0
    press(ACT_SET);
    press(ACT_CHANGE);                          // minute 63 wraps to 0
    press(ACT_SET);
    press(ACT_CHANGE);                          // month 63 wraps to 1
    press(ACT_SET);
    press(ACT_CHANGE);                          // day 63 wraps to 1
    press(ACT_ENTER);                           // all five chip writes
    press(ACT_ENTER);                           // nothing dirty: back to normal
    send_key(ACT_LOAD, 6'd23, 6'd59, 6'd12, 6'd31);
    press(ACT_SET);
    press(ACT_CHANGE);                          // hour 23 wraps to 0
    press(ACT_ENTER);                           // single hour write
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_SET);
    press(ACT_SET);                             // past screen 4: back to normal
    send_key(ACT_LOAD, 6'd0, 6'd0, 6'd0, 6'd0);
    press(ACT_ENTER);                           // temperature view off
    press(ACT_CHANGE);                          // date view off

    // Random part, one idling profile per phase.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      while (sent_cnt < DirectedCnt + (p + 1) * PhaseItems) random_chunk();
    end

    // The falling edge also lets the checker take in the last key beat.
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ckc_pkg.sv
hdl/ckc_if.sv
hdl/ckc_step.sv
hdl/ckc_emit.sv
hdl/clock_set_key_controller_core.sv
tb/ckc_checker.sv
tb/tb_top.sv
